// ===== rtl/pclb_pkg.sv =====
package pclb_pkg;

  localparam int MAX_ENTRIES    = 5;
  localparam int MAX_NAME_LEN   = 32;
  localparam int MAX_SECRET_LEN = 64;

  typedef enum logic [2:0] {
    PH_VERSION = 3'd0,
    PH_COUNT   = 3'd1,
    PH_NLEN    = 3'd2,
    PH_NBYTE   = 3'd3,
    PH_SLEN    = 3'd4,
    PH_SBYTE   = 3'd5,
    PH_DONE    = 3'd6,
    PH_ERROR   = 3'd7
  } phase_t;

  typedef logic [2:0] status_t;

  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_SHORT      = 3'd1;
  localparam status_t ST_VERSION    = 3'd2;
  localparam status_t ST_MANY       = 3'd3;
  localparam status_t ST_NAMELONG   = 3'd4;
  localparam status_t ST_SECRETLONG = 3'd5;
  localparam status_t ST_TRUNC      = 3'd6;
  localparam status_t ST_EMPTY      = 3'd7;

  typedef struct packed {
    logic [2:0] field_kind;
    logic [2:0] entry_number;
    logic [5:0] byte_offset;
    logic [7:0] byte_value;
    logic       error_seen;
    logic       is_final;
    status_t    final_status;
  } result_t;

endpackage

// ===== rtl/parse_credential_list_blob_top.sv =====
// Credential list blob parser.
// The slave stream carries the blob one byte per transaction, with tlast on the
// final byte. The master stream returns one tagged transaction per input byte:
// tuser gives the field kind, tdata the entry, the offset in its string, the
// byte itself, the error flag and, on the tlast transaction, the blob status.
// Downstream keeps a blob's bytes only if that status is ok.
// The cfg channel writes the expected version byte; it is always ready. The user
// must write it only while no transaction is in flight; the block does not enforce it.
// From input acceptance to output, a byte passes one input register, then the parse
// step into the output register. Throughput is one byte per cycle while the receiver
// is ready, limited only by the single parse state update per byte.
// When the receiver stalls, the output register holds and the input register
// fills; a third byte waits at the slave port until the output moves.
// Reset empties both registers, returns the parser to the version byte and
// sets the expected version to 1. After each tlast byte the parser restarts.
module parse_credential_list_blob_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,       // expected_version
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,        // [7:0] blob_byte
  input  logic        s_tlast,        // blob_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,        // [2:0] entry_number, [8:3] byte_offset,
                                      // [16:9] byte_value, [17] error_seen,
                                      // [20:18] final_status, [23:21] zero
  output logic [2:0]  m_tuser,        // [2:0] field_kind
  output logic        m_tlast         // is_final
);

  logic              in_valid;
  logic [7:0]        in_byte;
  logic              in_last;
  logic              out_valid;
  pclb_pkg::result_t out_res;
  pclb_pkg::result_t step_res;
  logic [7:0]        expected_version;
  logic              out_free;
  logic              advance;

  assign out_free  = !out_valid || m_tready;
  assign advance   = in_valid && out_free;
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= 8'd1;
    end else if (cfg_valid) begin
      expected_version <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  pclb_core u_core (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .blob_byte        (in_byte),
    .blob_end         (in_last),
    .expected_version (expected_version),
    .result           (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.field_kind;
  assign m_tlast  = out_res.is_final;
  assign m_tdata  = {3'b000, out_res.final_status, out_res.error_seen,
                     out_res.byte_value, out_res.byte_offset, out_res.entry_number};

endmodule

// ===== rtl/pclb_core.sv =====
module pclb_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        blob_byte,
  input  logic              blob_end,
  input  logic [7:0]        expected_version,
  output pclb_pkg::result_t result
);

  pclb_pkg::phase_t  parse_phase, parse_phase_next;
  logic [6:0]        bytes_left, bytes_left_next;
  logic [5:0]        string_offset, string_offset_next;
  logic [2:0]        current_entry, current_entry_next;
  logic [2:0]        entry_total, entry_total_next;
  pclb_pkg::status_t latched_status, latched_status_next;
  logic              name_empty, name_empty_next;

  pclb_pkg::phase_t  phase_work;
  pclb_pkg::phase_t  phase_after;
  pclb_pkg::status_t status_after;
  pclb_pkg::status_t status_end;
  logic              raise;
  pclb_pkg::status_t raise_code;
  logic [6:0]        left_dec;
  logic [3:0]        entry_inc;
  logic [2:0]        ent;
  logic [5:0]        off;

  always_comb begin
    phase_work         = parse_phase;
    bytes_left_next    = bytes_left;
    string_offset_next = string_offset;
    current_entry_next = current_entry;
    entry_total_next   = entry_total;
    name_empty_next    = name_empty;
    raise              = 1'b0;
    raise_code         = pclb_pkg::ST_OK;
    ent                = 3'd0;
    off                = 6'd0;
    left_dec           = bytes_left - 7'd1;
    entry_inc          = {1'b0, current_entry} + 4'd1;

    case (parse_phase)
      pclb_pkg::PH_VERSION: begin
        if (blob_end) begin
          raise      = 1'b1;
          raise_code = pclb_pkg::ST_SHORT;
        end else if (blob_byte != expected_version) begin
          raise      = 1'b1;
          raise_code = pclb_pkg::ST_VERSION;
        end else begin
          phase_work = pclb_pkg::PH_COUNT;
        end
      end
      pclb_pkg::PH_COUNT: begin
        if (blob_byte > 8'(pclb_pkg::MAX_ENTRIES)) begin
          raise      = 1'b1;
          raise_code = pclb_pkg::ST_MANY;
        end else begin
          entry_total_next   = blob_byte[2:0];
          current_entry_next = 3'd0;
          phase_work = (blob_byte == 8'd0) ? pclb_pkg::PH_DONE : pclb_pkg::PH_NLEN;
        end
      end
      pclb_pkg::PH_NLEN: begin
        ent = current_entry;
        if (blob_byte > 8'(pclb_pkg::MAX_NAME_LEN)) begin
          raise      = 1'b1;
          raise_code = pclb_pkg::ST_NAMELONG;
        end else begin
          name_empty_next    = (blob_byte == 8'd0);
          bytes_left_next    = blob_byte[6:0];
          string_offset_next = 6'd0;
          phase_work = (blob_byte == 8'd0) ? pclb_pkg::PH_SLEN : pclb_pkg::PH_NBYTE;
        end
      end
      pclb_pkg::PH_NBYTE: begin
        ent = current_entry;
        off = string_offset;
        if (string_offset == 6'd0 && blob_byte == 8'd0) begin
          name_empty_next = 1'b1;
        end
        string_offset_next = string_offset + 6'd1;
        bytes_left_next    = left_dec;
        if (left_dec == 7'd0) begin
          phase_work = pclb_pkg::PH_SLEN;
        end
      end
      pclb_pkg::PH_SLEN: begin
        ent = current_entry;
        if (blob_byte > 8'(pclb_pkg::MAX_SECRET_LEN)) begin
          raise      = 1'b1;
          raise_code = pclb_pkg::ST_SECRETLONG;
        end else begin
          bytes_left_next    = blob_byte[6:0];
          string_offset_next = 6'd0;
          if (blob_byte == 8'd0) begin
            // entry complete with an empty secret
            if (name_empty) begin
              raise      = 1'b1;
              raise_code = pclb_pkg::ST_EMPTY;
            end else begin
              current_entry_next = entry_inc[2:0];
              phase_work = (entry_inc >= {1'b0, entry_total}) ?
                           pclb_pkg::PH_DONE : pclb_pkg::PH_NLEN;
            end
          end else begin
            phase_work = pclb_pkg::PH_SBYTE;
          end
        end
      end
      pclb_pkg::PH_SBYTE: begin
        ent = current_entry;
        off = string_offset;
        string_offset_next = string_offset + 6'd1;
        bytes_left_next    = left_dec;
        if (left_dec == 7'd0) begin
          if (name_empty) begin
            raise      = 1'b1;
            raise_code = pclb_pkg::ST_EMPTY;
          end else begin
            current_entry_next = entry_inc[2:0];
            phase_work = (entry_inc >= {1'b0, entry_total}) ?
                         pclb_pkg::PH_DONE : pclb_pkg::PH_NLEN;
          end
        end
      end
      default: begin
      end
    endcase

    // first error wins
    status_after = (raise && latched_status == pclb_pkg::ST_OK) ? raise_code : latched_status;
    phase_after  = raise ? pclb_pkg::PH_ERROR : phase_work;
    status_end   = status_after;
    if (blob_end && status_after == pclb_pkg::ST_OK && phase_after != pclb_pkg::PH_DONE) begin
      status_end = pclb_pkg::ST_TRUNC;
    end

    parse_phase_next    = phase_after;
    latched_status_next = status_end;

    result.field_kind   = parse_phase;
    result.entry_number = ent;
    result.byte_offset  = off;
    result.byte_value   = blob_byte;
    result.error_seen   = (status_end != pclb_pkg::ST_OK);
    result.is_final     = blob_end;
    result.final_status = blob_end ? status_end : pclb_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= pclb_pkg::PH_VERSION;
      bytes_left     <= '0;
      string_offset  <= '0;
      current_entry  <= '0;
      entry_total    <= '0;
      latched_status <= pclb_pkg::ST_OK;
      name_empty     <= 1'b0;
    end else if (step) begin
      if (blob_end) begin
        // blob done, next byte starts a new one
        parse_phase    <= pclb_pkg::PH_VERSION;
        bytes_left     <= '0;
        string_offset  <= '0;
        current_entry  <= '0;
        entry_total    <= '0;
        latched_status <= pclb_pkg::ST_OK;
        name_empty     <= 1'b0;
      end else begin
        parse_phase    <= parse_phase_next;
        bytes_left     <= bytes_left_next;
        string_offset  <= string_offset_next;
        current_entry  <= current_entry_next;
        entry_total    <= entry_total_next;
        latched_status <= latched_status_next;
        name_empty     <= name_empty_next;
      end
    end
  end

endmodule

// ===== verif/parse_credential_list_blob_top_tb.sv =====
`timescale 1ns / 100ps

module parse_credential_list_blob_top_tb;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 3;
  localparam int DUT_LATENCY    = 2;
  localparam int RANDOM_BYTES   = 1550;
  localparam int N_SETTINGS     = 6;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct {
    logic [7:0]        blob_byte;
    logic              blob_end;
    bit                typed;
    pclb_pkg::result_t want;
  } step_row_t;

  typedef enum int {
    FLAW_NONE, FLAW_VERSION, FLAW_COUNT, FLAW_NAME_LEN, FLAW_SECRET_LEN,
    FLAW_EMPTY_NAME, FLAW_ZERO_NAME, FLAW_CUT, FLAW_CORRUPT, FLAW_LONE, FLAW_NOISE
  } blob_flaw_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_PERIODIC, RX_BLOCKED} rx_mode_t;

  localparam pclb_pkg::result_t UNTYPED = '0;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data  = 8'h00;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'h00;   // [7:0] blob_byte
  logic        s_tlast   = 1'b0;    // blob_end
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;             // [2:0] entry_number, [8:3] byte_offset,
                                    // [16:9] byte_value, [17] error_seen,
                                    // [20:18] final_status, [23:21] zero
  logic [2:0]  m_tuser;             // [2:0] field_kind
  logic        m_tlast;             // is_final

  // parser shadow state
  logic [7:0]         exp_version = 8'h01;
  pclb_pkg::phase_t   prs_phase   = pclb_pkg::PH_VERSION;
  logic [6:0]         left_cnt    = '0;
  logic [5:0]         str_off     = '0;
  logic [2:0]         ent_idx     = '0;
  logic [2:0]         ent_total   = '0;
  pclb_pkg::status_t  err_code    = pclb_pkg::ST_OK;
  logic               name_void   = 1'b0;

  step_row_t          blob_q[$];
  pclb_pkg::result_t  pending_tags[$];
  step_row_t          dir_tab[25];
  bit                 drv_typed = 1'b0;
  pclb_pkg::result_t  drv_want  = '0;
  int                 burst_left = 4;
  int                 gap_left   = 0;
  int                 rx_cyc     = 0;
  rx_mode_t           rx_mode    = RX_OPEN;
  int                 idle_cyc   = 0;
  int                 err_cnt    = 0;
  int                 stim_total = 0;
  int                 bytes_in   = 0;
  int                 blobs_done = 0;
  int                 cfg_writes = 0;
  int                 status_hist[8];

  parse_credential_list_blob_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #CLK_HALF clk = ~clk;

  function automatic pclb_pkg::result_t tag(pclb_pkg::phase_t kind, int ent, int off,
                                            logic [7:0] val, bit err, bit fin,
                                            pclb_pkg::status_t st);
    pclb_pkg::result_t r;
    r.field_kind   = kind;
    r.entry_number = ent[2:0];
    r.byte_offset  = off[5:0];
    r.byte_value   = val;
    r.error_seen   = err;
    r.is_final     = fin;
    r.final_status = st;
    return r;
  endfunction

  function automatic void restart_parse();
    prs_phase = pclb_pkg::PH_VERSION;
    left_cnt  = '0;
    str_off   = '0;
    ent_idx   = '0;
    ent_total = '0;
    err_code  = pclb_pkg::ST_OK;
    name_void = 1'b0;
  endfunction

  // only the first error code sticks
  function automatic void raise_err(pclb_pkg::status_t code);
    if (err_code == pclb_pkg::ST_OK) err_code = code;
    prs_phase = pclb_pkg::PH_ERROR;
  endfunction

  function automatic void close_entry();
    if (name_void) begin
      raise_err(pclb_pkg::ST_EMPTY);
    end else begin
      ent_idx++;
      if (ent_idx >= ent_total) prs_phase = pclb_pkg::PH_DONE;
      else prs_phase = pclb_pkg::PH_NLEN;
    end
  endfunction

  function automatic pclb_pkg::result_t tag_byte(logic [7:0] b, logic fin);
    pclb_pkg::result_t r;
    r = '0;
    r.field_kind = prs_phase;
    r.byte_value = b;
    case (prs_phase)
      pclb_pkg::PH_VERSION: begin
        if (fin) raise_err(pclb_pkg::ST_SHORT);
        else if (b != exp_version) raise_err(pclb_pkg::ST_VERSION);
        else prs_phase = pclb_pkg::PH_COUNT;
      end
      pclb_pkg::PH_COUNT: begin
        if (b > pclb_pkg::MAX_ENTRIES) begin
          raise_err(pclb_pkg::ST_MANY);
        end else begin
          ent_total = b[2:0];
          ent_idx   = '0;
          if (b == 0) prs_phase = pclb_pkg::PH_DONE;
          else prs_phase = pclb_pkg::PH_NLEN;
        end
      end
      pclb_pkg::PH_NLEN: begin
        r.entry_number = ent_idx;
        if (b > pclb_pkg::MAX_NAME_LEN) begin
          raise_err(pclb_pkg::ST_NAMELONG);
        end else begin
          name_void = (b == 0);
          left_cnt  = b[6:0];
          str_off   = '0;
          if (b == 0) prs_phase = pclb_pkg::PH_SLEN;
          else prs_phase = pclb_pkg::PH_NBYTE;
        end
      end
      pclb_pkg::PH_NBYTE: begin
        r.entry_number = ent_idx;
        r.byte_offset  = str_off;
        if (str_off == 0 && b == 0) name_void = 1'b1;
        str_off++;
        left_cnt--;
        if (left_cnt == 0) prs_phase = pclb_pkg::PH_SLEN;
      end
      pclb_pkg::PH_SLEN: begin
        r.entry_number = ent_idx;
        if (b > pclb_pkg::MAX_SECRET_LEN) begin
          raise_err(pclb_pkg::ST_SECRETLONG);
        end else begin
          left_cnt = b[6:0];
          str_off  = '0;
          if (b == 0) close_entry();
          else prs_phase = pclb_pkg::PH_SBYTE;
        end
      end
      pclb_pkg::PH_SBYTE: begin
        r.entry_number = ent_idx;
        r.byte_offset  = str_off;
        str_off++;
        left_cnt--;
        if (left_cnt == 0) close_entry();
      end
      default: ;
    endcase
    if (fin) begin
      if (err_code == pclb_pkg::ST_OK && prs_phase != pclb_pkg::PH_DONE)
        raise_err(pclb_pkg::ST_TRUNC);
      r.final_status = err_code;
    end
    r.error_seen = (err_code != pclb_pkg::ST_OK);
    r.is_final   = fin;
    if (fin) restart_parse();
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    err_cnt++;
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic fin);
    step_row_t row;
    row.blob_byte = b;
    row.blob_end  = fin;
    row.typed     = 1'b0;
    row.want      = UNTYPED;
    blob_q.push_back(row);
    stim_total++;
  endtask

  // mostly short strings, now and then the limit or anything up to it
  function automatic int pick_len(int top);
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return top;
    if (r == 1) return $urandom_range(1, top);
    return $urandom_range(1, 6);
  endfunction

  task automatic queue_blob();
    logic [7:0] bq[$];
    blob_flaw_t flaw;
    int         n_ent, bad_ent, nl, sl, cut, n;
    logic [7:0] b;
    if ($urandom_range(0, 99) < 70) flaw = FLAW_NONE;
    else flaw = blob_flaw_t'($urandom_range(FLAW_VERSION, FLAW_NOISE));
    if (flaw == FLAW_LONE) begin
      queue_byte(8'($urandom_range(0, 255)), 1'b1);
    end else if (flaw == FLAW_NOISE) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) queue_byte(8'($urandom_range(0, 255)), i == n - 1);
    end else begin
      n = $urandom_range(0, 9);
      if (n < 2) n_ent = 0;
      else if (n < 8) n_ent = $urandom_range(1, 3);
      else n_ent = $urandom_range(4, pclb_pkg::MAX_ENTRIES);
      if (flaw >= FLAW_NAME_LEN && flaw <= FLAW_ZERO_NAME && n_ent == 0) n_ent = 1;
      bad_ent = (n_ent > 0) ? $urandom_range(0, n_ent - 1) : 0;
      if (flaw == FLAW_VERSION) bq.push_back(exp_version ^ 8'($urandom_range(1, 255)));
      else bq.push_back(exp_version);
      if (flaw == FLAW_COUNT)
        bq.push_back(8'($urandom_range(pclb_pkg::MAX_ENTRIES + 1, 255)));
      else bq.push_back(8'(n_ent));
      for (int e = 0; e < n_ent; e++) begin
        nl = (flaw == FLAW_EMPTY_NAME && e == bad_ent) ? 0 : pick_len(pclb_pkg::MAX_NAME_LEN);
        sl = ($urandom_range(0, 5) == 0) ? 0 : pick_len(pclb_pkg::MAX_SECRET_LEN);
        // a bad length byte still gets short content, parsed as after error
        if (flaw == FLAW_NAME_LEN && e == bad_ent)
          bq.push_back(8'($urandom_range(pclb_pkg::MAX_NAME_LEN + 1, 255)));
        else bq.push_back(8'(nl));
        for (int i = 0; i < nl; i++) begin
          if (i > 0) b = 8'($urandom_range(0, 255));
          else if (flaw == FLAW_ZERO_NAME && e == bad_ent) b = 8'h00;
          else b = 8'($urandom_range(1, 255));
          bq.push_back(b);
        end
        if (flaw == FLAW_SECRET_LEN && e == bad_ent)
          bq.push_back(8'($urandom_range(pclb_pkg::MAX_SECRET_LEN + 1, 255)));
        else bq.push_back(8'(sl));
        for (int i = 0; i < sl; i++) bq.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) bq.push_back(8'($urandom_range(0, 255)));
      end
      if (flaw == FLAW_CUT) begin
        cut = $urandom_range(1, bq.size() - 1);
        while (bq.size() > cut) void'(bq.pop_back());
      end
      if (flaw == FLAW_CORRUPT) bq[$urandom_range(0, bq.size() - 1)] = 8'($urandom_range(0, 255));
      foreach (bq[i]) queue_byte(bq[i], i == bq.size() - 1);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (blob_q.size() != 0 || s_tvalid || pending_tags.size() != 0);
    repeat (DUT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_version(input logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    exp_version  = v;
    cfg_writes++;
  endtask

  // sender: bursts of random length with gaps, shadow parser steps on each transaction
  always @(posedge clk) begin
    step_row_t         nxt;
    pclb_pkg::result_t pred;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        pred = tag_byte(s_tdata, s_tlast);
        pending_tags.push_back(drv_typed ? drv_want : pred);
        bytes_in++;
        if (s_tlast) begin
          blobs_done++;
          status_hist[pred.final_status]++;
        end
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (blob_q.size() > 0) begin
          nxt = blob_q.pop_front();
          s_tvalid  <= 1'b1;
          s_tdata   <= nxt.blob_byte;
          s_tlast   <= nxt.blob_end;
          drv_typed <= nxt.typed;
          drv_want  <= nxt.want;
          burst_left--;
          if (burst_left <= 0) begin
            if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(100, 300);
            else burst_left = $urandom_range(1, 16);
            gap_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 12 : 3);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches now and then at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (rx_cyc == 0) begin
        rx_mode = rx_mode_t'($urandom_range(RX_OPEN, RX_BLOCKED));
        rx_cyc  = $urandom_range(20, 80);
      end
      rx_cyc--;
      case (rx_mode)
        RX_OPEN:     m_tready <= 1'b1;
        RX_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
        RX_PERIODIC: m_tready <= ((rx_cyc % 5) < 2);
        default:     m_tready <= ((rx_cyc % 16) >= 12);
      endcase
    end
  end

  always @(posedge clk) begin
    pclb_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_tags.size() == 0) begin
        flag_mismatch("transaction with nothing expected", 32'(m_tdata), 0);
      end else begin
        want = pending_tags.pop_front();
        if (m_tuser != want.field_kind)
          flag_mismatch("field_kind", 32'(m_tuser), 32'(want.field_kind));
        if (m_tdata[2:0] != want.entry_number)
          flag_mismatch("entry_number", 32'(m_tdata[2:0]), 32'(want.entry_number));
        if (m_tdata[8:3] != want.byte_offset)
          flag_mismatch("byte_offset", 32'(m_tdata[8:3]), 32'(want.byte_offset));
        if (m_tdata[16:9] != want.byte_value)
          flag_mismatch("byte_value", 32'(m_tdata[16:9]), 32'(want.byte_value));
        if (m_tdata[17] != want.error_seen)
          flag_mismatch("error_seen", 32'(m_tdata[17]), 32'(want.error_seen));
        if (m_tdata[20:18] != want.final_status)
          flag_mismatch("final_status", 32'(m_tdata[20:18]), 32'(want.final_status));
        if (m_tdata[23:21] != 3'd0)
          flag_mismatch("tdata padding", 32'(m_tdata[23:21]), 0);
        if (m_tlast != want.is_final)
          flag_mismatch("is_final", 32'(m_tlast), 32'(want.is_final));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cyc = 0;
    else
      idle_cyc++;
    if (idle_cyc >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, pending_tags.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [7:0] settings[N_SETTINGS];
    int         quota, start;
    foreach (status_hist[i]) status_hist[i] = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // version register still at its reset value here
    dir_tab = '{
      // count of zero: done right after the count byte
      '{8'h01, 1'b0, 1'b1,
        tag(pclb_pkg::PH_VERSION, 0, 0, 8'h01, 1'b0, 1'b0, pclb_pkg::ST_OK)},
      '{8'h00, 1'b1, 1'b1,
        tag(pclb_pkg::PH_COUNT, 0, 0, 8'h00, 1'b0, 1'b1, pclb_pkg::ST_OK)},
      // lone byte is too short whatever its value
      '{8'hFF, 1'b1, 1'b1,
        tag(pclb_pkg::PH_VERSION, 0, 0, 8'hFF, 1'b1, 1'b1, pclb_pkg::ST_SHORT)},
      // wrong version, next byte lands after the error
      '{8'h00, 1'b0, 1'b1,
        tag(pclb_pkg::PH_VERSION, 0, 0, 8'h00, 1'b1, 1'b0, pclb_pkg::ST_OK)},
      '{8'h00, 1'b1, 1'b1,
        tag(pclb_pkg::PH_ERROR, 0, 0, 8'h00, 1'b1, 1'b1, pclb_pkg::ST_VERSION)},
      // one entry over the count limit
      '{8'h01, 1'b0, 1'b0, UNTYPED},
      '{8'h06, 1'b1, 1'b1,
        tag(pclb_pkg::PH_COUNT, 0, 0, 8'h06, 1'b1, 1'b1, pclb_pkg::ST_MANY)},
      // name length one over the limit
      '{8'h01, 1'b0, 1'b0, UNTYPED},
      '{8'h01, 1'b0, 1'b0, UNTYPED},
      '{8'h21, 1'b1, 1'b1,
        tag(pclb_pkg::PH_NLEN, 0, 0, 8'h21, 1'b1, 1'b1, pclb_pkg::ST_NAMELONG)},
      // empty name, but secret length error in the same entry wins
      '{8'h01, 1'b0, 1'b0, UNTYPED},
      '{8'h01, 1'b0, 1'b0, UNTYPED},
      '{8'h00, 1'b0, 1'b0, UNTYPED},
      '{8'h41, 1'b1, 1'b1,
        tag(pclb_pkg::PH_SLEN, 0, 0, 8'h41, 1'b1, 1'b1, pclb_pkg::ST_SECRETLONG)},
      // name begins with a zero byte, rejected when the entry closes
      '{8'h01, 1'b0, 1'b0, UNTYPED},
      '{8'h01, 1'b0, 1'b0, UNTYPED},
      '{8'h01, 1'b0, 1'b0, UNTYPED},
      '{8'h00, 1'b0, 1'b0, UNTYPED},
      '{8'h00, 1'b1, 1'b1,
        tag(pclb_pkg::PH_SLEN, 0, 0, 8'h00, 1'b1, 1'b1, pclb_pkg::ST_EMPTY)},
      // trailing byte after a complete blob
      '{8'h01, 1'b0, 1'b0, UNTYPED},
      '{8'h00, 1'b0, 1'b0, UNTYPED},
      '{8'hAB, 1'b1, 1'b1,
        tag(pclb_pkg::PH_DONE, 0, 0, 8'hAB, 1'b0, 1'b1, pclb_pkg::ST_OK)},
      // end inside the entries: truncated
      '{8'h01, 1'b0, 1'b0, UNTYPED},
      '{8'h02, 1'b0, 1'b0, UNTYPED},
      '{8'h03, 1'b1, 1'b1,
        tag(pclb_pkg::PH_NLEN, 0, 0, 8'h03, 1'b1, 1'b1, pclb_pkg::ST_TRUNC)}
    };
    foreach (dir_tab[i]) begin
      blob_q.push_back(dir_tab[i]);
      stim_total++;
    end
    wait_idle();

    settings = '{8'hFF, 8'h00, 8'($urandom_range(2, 254)), 8'h01,
                 8'($urandom_range(0, 255)), 8'h80};
    quota = RANDOM_BYTES / N_SETTINGS;
    for (int p = 0; p < N_SETTINGS; p++) begin
      write_version(settings[p]);
      start = stim_total;
      while (stim_total - start < quota) queue_blob();
      wait_idle();
    end

    $display("run covered %0d bytes in %0d blobs across %0d version settings",
             bytes_in, blobs_done, cfg_writes);
    $display("final status ok %0d short %0d version %0d many %0d name %0d",
             status_hist[pclb_pkg::ST_OK], status_hist[pclb_pkg::ST_SHORT],
             status_hist[pclb_pkg::ST_VERSION], status_hist[pclb_pkg::ST_MANY],
             status_hist[pclb_pkg::ST_NAMELONG]);
    $display("  secret %0d trunc %0d empty %0d",
             status_hist[pclb_pkg::ST_SECRETLONG], status_hist[pclb_pkg::ST_TRUNC],
             status_hist[pclb_pkg::ST_EMPTY]);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
